FILE: src/alisd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alisd_pkg
// Shared types, request codes and microcode table for the array list block.
// ----------------------------------------------------------------------------
package alisd_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 4;
  localparam int REQ_W        = 3;
  localparam int UPC_W        = 5;

  // request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEXT        = 4'd0,
    C_ALWAYS      = 4'd1,
    C_FULL        = 4'd2,
    C_NOT_FULL    = 4'd3,
    C_POS_GT_CNT  = 4'd4,
    C_POS_GE_CNT  = 4'd5,
    C_PTR_LE_POS  = 4'd6,
    C_PTR_GE_LAST = 4'd7,
    C_PTR_LT_LAST = 4'd8,
    C_PTR_GE_CNT  = 4'd9,
    C_HIT         = 4'd10,
    C_NO_ADD      = 4'd11
  } cond_t;

  typedef enum logic [2:0] {
    A_PTR    = 3'd0,
    A_PTR_M1 = 3'd1,
    A_PTR_P1 = 3'd2,
    A_POS    = 3'd3,
    A_CNT    = 3'd4
  } addr_sel_t;

  typedef enum logic {
    WD_VALUE = 1'b0,
    WD_RDATA = 1'b1
  } wd_sel_t;

  typedef enum logic [2:0] {
    P_HOLD   = 3'd0,
    P_INC    = 3'd1,
    P_DEC    = 3'd2,
    P_LD_CNT = 3'd3,
    P_LD_POS = 3'd4
  } ptr_op_t;

  typedef enum logic [1:0] {
    N_HOLD = 2'd0,
    N_INC  = 2'd1,
    N_DEC  = 2'd2
  } cnt_op_t;

  typedef enum logic [1:0] {
    I_ZERO = 2'd0,
    I_PTR  = 2'd1,
    I_POS  = 2'd2,
    I_CNT  = 2'd3
  } idx_sel_t;

  typedef struct packed {
    cond_t            cond;
    logic [UPC_W-1:0] target;
    addr_sel_t        addr;
    logic             re;
    logic             we;
    wd_sel_t          wd;
    ptr_op_t          ptr_op;
    cnt_op_t          cnt_op;
    logic             done;
    status_t          st;
    logic             found;
    idx_sel_t         idx;
    logic             dat;
  } uword_t;

  // microcode addresses
  localparam logic [UPC_W-1:0] U_APP      = 5'd0;
  localparam logic [UPC_W-1:0] U_PUSH     = 5'd1;
  localparam logic [UPC_W-1:0] U_INS      = 5'd2;
  localparam logic [UPC_W-1:0] U_INS_CHK  = 5'd3;
  localparam logic [UPC_W-1:0] U_INS_LOOP = 5'd4;
  localparam logic [UPC_W-1:0] U_INS_RD   = 5'd5;
  localparam logic [UPC_W-1:0] U_INS_WR   = 5'd6;
  localparam logic [UPC_W-1:0] U_INS_PUT  = 5'd7;
  localparam logic [UPC_W-1:0] U_SRCH     = 5'd8;
  localparam logic [UPC_W-1:0] U_CMP      = 5'd9;
  localparam logic [UPC_W-1:0] U_ADV      = 5'd10;
  localparam logic [UPC_W-1:0] U_MISS     = 5'd11;
  localparam logic [UPC_W-1:0] U_ADD      = 5'd12;
  localparam logic [UPC_W-1:0] U_SFULL    = 5'd13;
  localparam logic [UPC_W-1:0] U_NOADD    = 5'd14;
  localparam logic [UPC_W-1:0] U_HIT      = 5'd15;
  localparam logic [UPC_W-1:0] U_DEL      = 5'd16;
  localparam logic [UPC_W-1:0] U_DEL_LOOP = 5'd17;
  localparam logic [UPC_W-1:0] U_DEL_RD   = 5'd18;
  localparam logic [UPC_W-1:0] U_DEL_WR   = 5'd19;
  localparam logic [UPC_W-1:0] U_DEL_END  = 5'd20;
  localparam logic [UPC_W-1:0] U_RD       = 5'd21;
  localparam logic [UPC_W-1:0] U_RD_OUT   = 5'd22;
  localparam logic [UPC_W-1:0] U_FULL     = 5'd23;
  localparam logic [UPC_W-1:0] U_RANGE    = 5'd24;
  localparam logic [UPC_W-1:0] U_NOP      = 5'd25;

  localparam uword_t UW_IDLE = '{
    cond: C_NEXT, target: '0, addr: A_PTR, re: 1'b0, we: 1'b0, wd: WD_VALUE,
    ptr_op: P_HOLD, cnt_op: N_HOLD, done: 1'b0, st: ST_OK, found: 1'b0,
    idx: I_ZERO, dat: 1'b0
  };

  function automatic logic [UPC_W-1:0] entry_pc(input logic [REQ_W-1:0] req);
    logic [UPC_W-1:0] pc;
    unique case (req)
      REQ_APPEND: pc = U_APP;
      REQ_INSERT: pc = U_INS;
      REQ_SEARCH: pc = U_SRCH;
      REQ_DELETE: pc = U_DEL;
      REQ_READ:   pc = U_RD;
      default:    pc = U_NOP;
    endcase
    return pc;
  endfunction

  function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
    uword_t w;
    w = UW_IDLE;
    unique case (pc)
      // append
      U_APP: begin
        w.cond = C_FULL; w.target = U_FULL;
      end
      U_PUSH: begin
        w.we = 1'b1; w.addr = A_CNT; w.wd = WD_VALUE; w.cnt_op = N_INC;
        w.done = 1'b1; w.idx = I_CNT;
      end
      // insert: shift up from the tail, one entry per pass
      U_INS: begin
        w.cond = C_FULL; w.target = U_FULL;
      end
      U_INS_CHK: begin
        w.cond = C_POS_GT_CNT; w.target = U_RANGE; w.ptr_op = P_LD_CNT;
      end
      U_INS_LOOP: begin
        w.cond = C_PTR_LE_POS; w.target = U_INS_PUT;
      end
      U_INS_RD: begin
        w.re = 1'b1; w.addr = A_PTR_M1;
      end
      U_INS_WR: begin
        w.we = 1'b1; w.addr = A_PTR; w.wd = WD_RDATA; w.ptr_op = P_DEC;
        w.cond = C_ALWAYS; w.target = U_INS_LOOP;
      end
      U_INS_PUT: begin
        w.we = 1'b1; w.addr = A_POS; w.wd = WD_VALUE; w.cnt_op = N_INC;
        w.done = 1'b1; w.idx = I_POS;
      end
      // search: pointer starts at zero, the next entry is read after each failed compare
      U_SRCH: begin
        w.cond = C_PTR_GE_CNT; w.target = U_MISS; w.re = 1'b1; w.addr = A_PTR;
      end
      U_CMP: begin
        w.cond = C_HIT; w.target = U_HIT;
      end
      U_ADV: begin
        w.ptr_op = P_INC; w.re = 1'b1; w.addr = A_PTR_P1;
        w.cond = C_PTR_LT_LAST; w.target = U_CMP;
      end
      U_MISS: begin
        w.cond = C_NO_ADD; w.target = U_NOADD;
      end
      U_ADD: begin
        w.cond = C_NOT_FULL; w.target = U_PUSH;
      end
      U_SFULL: begin
        w.done = 1'b1; w.st = ST_FULL; w.idx = I_CNT;
      end
      U_NOADD: begin
        w.done = 1'b1; w.st = ST_MISSING; w.idx = I_CNT;
      end
      U_HIT: begin
        w.done = 1'b1; w.found = 1'b1; w.idx = I_PTR;
      end
      // delete: shift down from the position
      U_DEL: begin
        w.cond = C_POS_GE_CNT; w.target = U_RANGE; w.ptr_op = P_LD_POS;
      end
      U_DEL_LOOP: begin
        w.cond = C_PTR_GE_LAST; w.target = U_DEL_END;
      end
      U_DEL_RD: begin
        w.re = 1'b1; w.addr = A_PTR_P1;
      end
      U_DEL_WR: begin
        w.we = 1'b1; w.addr = A_PTR; w.wd = WD_RDATA; w.ptr_op = P_INC;
        w.cond = C_ALWAYS; w.target = U_DEL_LOOP;
      end
      U_DEL_END: begin
        w.cnt_op = N_DEC; w.done = 1'b1; w.idx = I_POS;
      end
      // read
      U_RD: begin
        w.cond = C_POS_GE_CNT; w.target = U_RANGE; w.re = 1'b1; w.addr = A_POS;
      end
      U_RD_OUT: begin
        w.done = 1'b1; w.idx = I_POS; w.dat = 1'b1;
      end
      U_FULL: begin
        w.done = 1'b1; w.st = ST_FULL;
      end
      U_RANGE: begin
        w.done = 1'b1; w.st = ST_RANGE;
      end
      default: begin
        // unused codes and spare steps finish with no change
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: src/array_list_insert_search_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_search_delete
// Dense ordered list of signed words with append, insert, search, delete, read.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the request completes, and its result appears for one cycle with done
// high, so the receiver must capture it on that cycle. Every request is run by
// a small microcode program over a single-port entry store with registered
// read data; insert and delete shift one entry per loop pass, and search
// reads and compares entries in turn from entry zero. done is registered from
// the last step, and a new request may be started in the cycle that done is
// high. The entry store is not cleared at reset; entries at or above the count
// may be read, but their data never reaches a result.
module array_list_insert_search_delete
  import alisd_pkg::*;
#(
  parameter int  CAPACITY = CAPACITY_DEF,
  localparam int CNT_W    = $clog2(CAPACITY + 1),
  localparam int AW       = $clog2(CAPACITY)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [REQ_W-1:0]        req_type,
  input  logic signed [VAL_W-1:0] value,
  input  logic [POS_W-1:0]        position,
  input  logic                    add_if_missing,
  output logic                    done,
  output status_t                 status,
  output logic                    found,
  output logic [CNT_W-1:0]        index,
  output logic signed [VAL_W-1:0] data,
  output logic [CNT_W-1:0]        count
);

  localparam int CW = CNT_W + POS_W;

  logic [UPC_W-1:0]        upc;
  logic [UPC_W-1:0]        upc_next;
  uword_t                  uw;
  logic signed [VAL_W-1:0] value_q;
  logic [POS_W-1:0]        pos_q;
  logic                    add_q;
  logic [CNT_W-1:0]        ptr;
  logic [CNT_W-1:0]        ptr_next;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_next;
  logic [CNT_W-1:0]        addr_full;
  logic [AW-1:0]           addr;
  logic signed [VAL_W-1:0] wdata;
  logic signed [VAL_W-1:0] rdata;
  logic [CNT_W-1:0]        idx_val;
  logic [CW-1:0]           pos_w;
  logic [CW-1:0]           cnt_w;
  logic [CW-1:0]           ptr_w;
  logic [CW-1:0]           ptr_p1_w;
  logic                    full;
  logic                    cond_true;

  logic signed [VAL_W-1:0] mem [CAPACITY];

  assign uw       = ucode(upc);
  assign pos_w    = CW'(pos_q);
  assign cnt_w    = CW'(cnt);
  assign ptr_w    = CW'(ptr);
  assign ptr_p1_w = ptr_w + CW'(1);
  assign full     = (cnt == CNT_W'(CAPACITY));

  always_comb begin
    unique case (uw.cond)
      C_NEXT:        cond_true = 1'b0;
      C_ALWAYS:      cond_true = 1'b1;
      C_FULL:        cond_true = full;
      C_NOT_FULL:    cond_true = !full;
      C_POS_GT_CNT:  cond_true = (pos_w > cnt_w);
      C_POS_GE_CNT:  cond_true = (pos_w >= cnt_w);
      C_PTR_LE_POS:  cond_true = (ptr_w <= pos_w);
      C_PTR_GE_LAST: cond_true = (ptr_p1_w >= cnt_w);
      C_PTR_LT_LAST: cond_true = (ptr_p1_w < cnt_w);
      C_PTR_GE_CNT:  cond_true = (ptr_w >= cnt_w);
      C_HIT:         cond_true = (rdata == value_q);
      C_NO_ADD:      cond_true = !add_q;
      default:       cond_true = 1'b0;
    endcase
  end

  assign upc_next = cond_true ? uw.target : upc + UPC_W'(1);

  always_comb begin
    unique case (uw.ptr_op)
      P_HOLD:   ptr_next = ptr;
      P_INC:    ptr_next = ptr + CNT_W'(1);
      P_DEC:    ptr_next = ptr - CNT_W'(1);
      P_LD_CNT: ptr_next = cnt;
      P_LD_POS: ptr_next = CNT_W'(pos_w);
      default:  ptr_next = ptr;
    endcase
  end

  always_comb begin
    unique case (uw.cnt_op)
      N_HOLD:  cnt_next = cnt;
      N_INC:   cnt_next = cnt + CNT_W'(1);
      N_DEC:   cnt_next = cnt - CNT_W'(1);
      default: cnt_next = cnt;
    endcase
  end

  always_comb begin
    unique case (uw.addr)
      A_PTR:    addr_full = ptr;
      A_PTR_M1: addr_full = ptr - CNT_W'(1);
      A_PTR_P1: addr_full = ptr + CNT_W'(1);
      A_POS:    addr_full = CNT_W'(pos_w);
      A_CNT:    addr_full = cnt;
      default:  addr_full = ptr;
    endcase
  end

  assign addr  = addr_full[AW-1:0];
  assign wdata = (uw.wd == WD_RDATA) ? rdata : value_q;

  always_comb begin
    unique case (uw.idx)
      I_ZERO:  idx_val = '0;
      I_PTR:   idx_val = ptr;
      I_POS:   idx_val = CNT_W'(pos_w);
      I_CNT:   idx_val = cnt;
      default: idx_val = '0;
    endcase
  end

  // entry store: one port, registered read
  always_ff @(posedge clk) begin
    if (busy && uw.we) begin
      mem[addr] <= wdata;
    end
    if (busy && uw.re) begin
      rdata <= mem[addr];
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      upc  <= U_NOP;
      cnt  <= '0;
    end else begin
      done <= busy && uw.done;
      if (!busy) begin
        if (start) begin
          busy <= 1'b1;
          upc  <= entry_pc(req_type);
        end
      end else begin
        upc <= upc_next;
        cnt <= cnt_next;
        if (uw.done) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // request operands, pointer and result registers
  always_ff @(posedge clk) begin
    if (!busy && start) begin
      value_q <= value;
      pos_q   <= position;
      add_q   <= add_if_missing;
      ptr     <= '0;
    end else if (busy) begin
      ptr <= ptr_next;
    end
    if (busy && uw.done) begin
      status <= uw.st;
      found  <= uw.found;
      index  <= idx_val;
      data   <= uw.dat ? rdata : '0;
      count  <= cnt_next;
    end
  end

endmodule
